### rtl/core/bmpd_pkg.sv
// Package for the banked memory pager and port decoder.
// Holds the word types, access codes, decode masks and bank constants.
// No dependencies; every other file in rtl/core but bmpd_cfg_if imports it.
package bmpd_pkg;

	// 16 KiB slots: the low address bits give the offset within a bank
	localparam int PAGE_BITS = 14;

	// access type codes
	localparam logic [1:0] REQ_MEM_RD = 2'd0;
	localparam logic [1:0] REQ_MEM_WR = 2'd1;
	localparam logic [1:0] REQ_IO_RD  = 2'd2;
	localparam logic [1:0] REQ_IO_WR  = 2'd3;

	// sound chip actions
	localparam logic [1:0] AY_NONE  = 2'd0;
	localparam logic [1:0] AY_SEL   = 2'd1;
	localparam logic [1:0] AY_WRITE = 2'd2;
	localparam logic [1:0] AY_READ  = 2'd3;

	// io read sources
	localparam logic [2:0] SRC_NONE  = 3'd0;
	localparam logic [2:0] SRC_JOY   = 3'd1;
	localparam logic [2:0] SRC_AY    = 3'd2;
	localparam logic [2:0] SRC_FBUS  = 3'd3;
	localparam logic [2:0] SRC_KEYB  = 3'd4;

	// slot numbers (address bits 15..14)
	localparam logic [1:0] SLOT_ROM  = 2'd0;
	localparam logic [1:0] SLOT_SCR  = 2'd1;
	localparam logic [1:0] SLOT_MID  = 2'd2;
	localparam logic [1:0] SLOT_PAGE = 2'd3;

	// port decode masks and matches
	localparam logic [15:0] PAGING_MASK  = 16'h8002;
	localparam logic [15:0] AY_MASK      = 16'hC002;
	localparam logic [15:0] AY_SEL_PORT  = 16'hC000;
	localparam logic [15:0] AY_DATA_PORT = 16'h8000;
	localparam logic [7:0]  JOY_PORT     = 8'h1F;

	// fixed banks
	localparam logic [2:0] BANK_SLOT1 = 3'd5;
	localparam logic [2:0] BANK_SLOT2 = 3'd2;
	localparam logic [2:0] SCR_NORMAL = 3'd5;
	localparam logic [2:0] SCR_SHADOW = 3'd7;

	// paging register bits
	localparam int PG_RAM_LSB  = 0;
	localparam int PG_SCREEN   = 3;
	localparam int PG_ROM      = 4;
	localparam int PG_LOCK     = 5;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [15:0] address;
		logic [7:0]  write_data;
		logic [7:0]  floating_bus;
	} req_t;

	typedef struct packed {
		logic                 phys_is_rom;
		logic [2:0]           phys_bank;
		logic [PAGE_BITS-1:0] phys_offset;
		logic                 mem_write_enable;
		logic                 contended;
		logic                 display_catch_up;
		logic [1:0]           ay_action;
		logic [2:0]           io_read_source;
		logic [7:0]           io_read_data;
		logic [2:0]           border_color;
		logic [1:0]           beeper_bits;
		logic [2:0]           screen_bank;
	} rsp_t;

	// architectural state carried between words
	typedef struct packed {
		logic [7:0] paging;
		logic       locked;
		logic [2:0] border;
		logic [1:0] beeper;
	} pg_state_t;

endpackage

### rtl/core/bmpd_req_if.sv
// Request channel: valid/ready handshake carrying one CPU access word.
// Depends on bmpd_pkg for req_t.
interface bmpd_req_if import bmpd_pkg::*; ();
	logic valid;
	logic ready;
	req_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### rtl/core/bmpd_rsp_if.sv
// Result channel: valid/ready handshake carrying one decode result word.
// Depends on bmpd_pkg for rsp_t.
interface bmpd_rsp_if import bmpd_pkg::*; ();
	logic valid;
	logic ready;
	rsp_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### rtl/core/bmpd_cfg_if.sv
// Configuration write channel: valid/ready carrying the fast-load mode bit.
// Depends on bmpd_pkg only by convention; no package types used.
interface bmpd_cfg_if ();
	logic valid;
	logic ready;
	logic data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### rtl/core/bmpd_decode.sv
// Single-pass access decoder: maps one access word onto bank, port and state.
// Purely combinational; depends on bmpd_pkg.
module bmpd_decode import bmpd_pkg::*; (
	input  req_t      item,
	input  pg_state_t st,
	input  logic      fast,
	output rsp_t      res,
	output pg_state_t st_nxt
);

	logic [1:0] slot;
	logic       ld_en;
	logic [7:0] ld_val;
	logic       catchup;
	logic       cont;
	logic       pg_port;
	logic [15:0] ay_bits;

	assign slot    = item.address[15:14];
	assign pg_port = (item.address & PAGING_MASK) == 16'h0000;
	assign ay_bits = item.address & AY_MASK;

	always_comb begin
		res     = '0;
		st_nxt  = st;
		ld_en   = 1'b0;
		ld_val  = 8'h00;
		catchup = 1'b0;
		// paging as it stood before this access
		cont = (slot == SLOT_SCR) || (slot == SLOT_PAGE && st.paging[PG_RAM_LSB]);

		unique case (item.req_type) inside
			REQ_MEM_RD, REQ_MEM_WR: begin
				res.phys_offset = item.address[PAGE_BITS-1:0];
				case (slot)
					SLOT_ROM: begin
						res.phys_is_rom = 1'b1;
						res.phys_bank   = {2'b00, st.paging[PG_ROM]};
					end
					SLOT_SCR:  res.phys_bank = BANK_SLOT1;
					SLOT_MID:  res.phys_bank = BANK_SLOT2;
					default:   res.phys_bank = st.paging[2:0];
				endcase
				if (item.req_type == REQ_MEM_WR && slot != SLOT_ROM) begin
					res.mem_write_enable = 1'b1;
					catchup              = (slot == SLOT_SCR);
				end
			end
			REQ_IO_RD: begin
				if (item.address[0]) begin
					if (item.address[7:0] == JOY_PORT) begin
						res.io_read_source = SRC_JOY;
					end else if (ay_bits == AY_SEL_PORT) begin
						res.io_read_source = SRC_AY;
						res.ay_action      = AY_READ;
					end else begin
						// floating bus lands in the paging register
						ld_en              = pg_port && !st.locked;
						ld_val             = item.floating_bus;
						res.io_read_source = SRC_FBUS;
						res.io_read_data   = item.floating_bus;
					end
				end else begin
					res.io_read_source = SRC_KEYB;
				end
			end
			default: begin
				ld_en  = pg_port && !st.locked;
				ld_val = item.write_data;
				if (ay_bits == AY_SEL_PORT) begin
					res.ay_action = AY_SEL;
				end else if (ay_bits == AY_DATA_PORT) begin
					res.ay_action = AY_WRITE;
				end
				if (!item.address[0]) begin
					catchup       = 1'b1;
					st_nxt.beeper = {item.write_data[4], item.write_data[3]};
					st_nxt.border = item.write_data[2:0];
				end
			end
		endcase

		if (ld_en) begin
			st_nxt.paging = ld_val;
			if (ld_val[PG_LOCK]) begin
				st_nxt.locked = 1'b1;
			end
			if (ld_val[PG_SCREEN] != st.paging[PG_SCREEN]) begin
				catchup = 1'b1;
			end
		end

		res.contended        = cont && !fast;
		res.display_catch_up = catchup && !fast;
		res.border_color     = st_nxt.border;
		res.beeper_bits      = st_nxt.beeper;
		res.screen_bank      = st_nxt.paging[PG_SCREEN] ? SCR_SHADOW : SCR_NORMAL;
	end

endmodule

### rtl/core/banked_memory_and_port_decoder_unit.sv
// Banked memory pager and io port decoder: one CPU access word in, one
// result word out. A word accepted into the input register is decoded out
// of it, and its result is loaded into the result register once that is
// free or being emptied; rsp presents it from there. The block sustains
// one word per clock while the result side keeps ready high. The paging,
// lock, border and beeper state is read and updated in the decode logic
// between the two registers, so back-to-back accesses always see the
// state left by the one before. Under back-pressure the result register
// holds and the input register fills, then req.ready drops. The user must
// write the fast-load bit through cfg only while idle; the block does not
// enforce this. The bit masks the contention and display catch-up strobes.
// There is no clearing pass after reset.
// Depends on bmpd_pkg, the three channel interfaces and bmpd_decode.
module banked_memory_and_port_decoder_unit import bmpd_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	bmpd_req_if.sink   req,
	bmpd_rsp_if.source rsp,
	bmpd_cfg_if.sink   cfg
);

	// input stage
	logic      valid_s1;
	req_t      req_s1;
	// result stage
	logic      valid_s2;
	rsp_t      rsp_s2;
	// architectural state and config
	pg_state_t state_q;
	logic      fast_q;

	pg_state_t state_nxt;
	rsp_t      rsp_nxt;
	logic      advance;

	// stage 1 moves into the result register when the latter is free or
	// being emptied this cycle
	assign advance   = valid_s1 && (!valid_s2 || rsp.ready);
	assign req.ready = !valid_s1 || advance;
	assign cfg.ready = 1'b1;

	assign rsp.valid = valid_s2;
	assign rsp.data  = rsp_s2;

	bmpd_decode u_decode (
		.item   (req_s1),
		.st     (state_q),
		.fast   (fast_q),
		.res    (rsp_nxt),
		.st_nxt (state_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			req_s1 <= req.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (rsp.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rsp_s2 <= rsp_nxt;
		end
	end

	// state commits only when its word leaves the decode stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fast_q <= 1'b0;
		end else if (cfg.valid && cfg.ready) begin
			fast_q <= cfg.data;
		end
	end

`ifndef NO_ASSERTIONS
	// lock is sticky until reset
	a_lock_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.locked |=> state_q.locked)
		else $error("paging lock cleared without reset");

	// once locked, the paging register never changes
	a_lock_holds: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.locked |=> $stable(state_q.paging))
		else $error("paging register changed while locked");

	// a decoded word always lands in the result register
	a_advance_fills: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> valid_s2)
		else $error("result register empty after advance");

	// a sound chip action only comes from an io access
	a_ay_is_io: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && rsp_s2.ay_action != AY_NONE) |->
			(!rsp_s2.mem_write_enable && !rsp_s2.phys_is_rom &&
			 rsp_s2.phys_offset == '0))
		else $error("io result carries memory fields");
`endif

endmodule

### sim/tb_banked_memory_and_port_decoder_unit.sv
`timescale 1ns / 100ps
// Self-checking bench for the banked memory pager and io port decoder.
// Needs bmpd_pkg, the three bmpd_*_if channel interfaces and the top-level RTL.
module tb_banked_memory_and_port_decoder_unit;
	import bmpd_pkg::*;

	// receiver back-pressure styles, picked per stretch of cycles
	typedef enum logic [1:0] {
		RDY_ALWAYS,
		RDY_COIN,
		RDY_PATTERN,
		RDY_MOSTLY
	} rdy_mode_t;

	logic clk;
	logic arst_n;

	bmpd_req_if req ();
	bmpd_rsp_if rsp ();
	bmpd_cfg_if cfg ();

	banked_memory_and_port_decoder_unit DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req.sink),
		.rsp    (rsp.source),
		.cfg    (cfg.sink)
	);

	// access words waiting for the driver, decode words waiting for the DUT
	req_t pending_accesses[$];
	rsp_t predicted_results[$];
	int   accesses_queued;
	int   accesses_taken;
	int   mismatches;
	bit   word_taken;  // set at posedge when req handshake happened

	// predictor's own copy of the architectural state and the mode bit
	logic [7:0] pg_reg;
	logic       pg_locked;
	logic [2:0] border_q;
	logic [1:0] beeper_q;
	logic       fast_mode;

	rsp_t want_word;

	// sender burst / gap shaping
	int burst_left;
	int gap_left;

	// receiver stall shaping
	rdy_mode_t  rdy_mode;
	int         rdy_left;
	logic [7:0] rdy_pattern;

	// 8 ns clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// hard stop far beyond the slowest legal run
	initial begin
		#4ms;
		$display("banked_memory_and_port_decoder_unit regression: fail");
		$finish;
	end

	// ---------------------------------------------------------------
	// Predictor
	// ---------------------------------------------------------------

	// load the paging register; flag a screen bank flip for catch-up
	function automatic logic apply_paging(logic [7:0] v);
		logic flipped;
		flipped = v[PG_SCREEN] != pg_reg[PG_SCREEN];
		pg_reg = v;
		if (v[PG_LOCK])
			pg_locked = 1'b1;
		return flipped;
	endfunction

	// decode one access word and advance the state as the block would
	function automatic rsp_t predict_access(req_t a);
		rsp_t       r;
		logic [1:0] slot;
		r = '0;
		slot = a.address[15:14];
		// contention uses paging as it stood before this access
		r.contended = (slot == SLOT_SCR) || (slot == SLOT_PAGE && pg_reg[PG_RAM_LSB]);
		case (a.req_type)
			REQ_MEM_RD, REQ_MEM_WR: begin
				r.phys_offset = a.address[PAGE_BITS-1:0];
				case (slot)
					SLOT_ROM: begin
						r.phys_is_rom = 1'b1;
						r.phys_bank = {2'b00, pg_reg[PG_ROM]};
					end
					SLOT_SCR: r.phys_bank = BANK_SLOT1;
					SLOT_MID: r.phys_bank = BANK_SLOT2;
					default: r.phys_bank = pg_reg[PG_RAM_LSB +: 3];
				endcase
				// ROM slot is write protected; screen slot writes need catch-up
				if (a.req_type == REQ_MEM_WR && slot != SLOT_ROM) begin
					r.mem_write_enable = 1'b1;
					r.display_catch_up = (slot == SLOT_SCR);
				end
			end
			REQ_IO_RD: begin
				if (a.address[0]) begin
					// odd port: joystick wins, then AY read, else floating bus
					if (a.address[7:0] == JOY_PORT) begin
						r.io_read_source = SRC_JOY;
					end else if ((a.address & AY_MASK) == AY_SEL_PORT) begin
						r.io_read_source = SRC_AY;
						r.ay_action = AY_READ;
					end else begin
						// reading the paging port latches the floating bus byte
						if ((a.address & PAGING_MASK) == '0 && !pg_locked)
							r.display_catch_up = apply_paging(a.floating_bus);
						r.io_read_source = SRC_FBUS;
						r.io_read_data = a.floating_bus;
					end
				end else begin
					r.io_read_source = SRC_KEYB;
				end
			end
			default: begin
				if ((a.address & PAGING_MASK) == '0 && !pg_locked)
					r.display_catch_up = apply_paging(a.write_data);
				if ((a.address & AY_MASK) == AY_SEL_PORT)
					r.ay_action = AY_SEL;
				else if ((a.address & AY_MASK) == AY_DATA_PORT)
					r.ay_action = AY_WRITE;
				// even port: border and beeper, always a catch-up
				if (!a.address[0]) begin
					r.display_catch_up = 1'b1;
					beeper_q = {a.write_data[4], a.write_data[3]};
					border_q = a.write_data[2:0];
				end
			end
		endcase
		if (fast_mode) begin
			r.contended = 1'b0;
			r.display_catch_up = 1'b0;
		end
		r.border_color = border_q;
		r.beeper_bits = beeper_q;
		r.screen_bank = pg_reg[PG_SCREEN] ? SCR_SHADOW : SCR_NORMAL;
		return r;
	endfunction

	// ---------------------------------------------------------------
	// Checking
	// ---------------------------------------------------------------

	task automatic check_field(string label, int unsigned want, int unsigned got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, label, want, got);
			mismatches++;
		end
	endtask

	task automatic check_result(rsp_t w, rsp_t g);
		check_field("phys_is_rom", 32'(w.phys_is_rom), 32'(g.phys_is_rom));
		check_field("phys_bank", 32'(w.phys_bank), 32'(g.phys_bank));
		check_field("phys_offset", 32'(w.phys_offset), 32'(g.phys_offset));
		check_field("mem_write_enable", 32'(w.mem_write_enable),
			32'(g.mem_write_enable));
		check_field("contended", 32'(w.contended), 32'(g.contended));
		check_field("display_catch_up", 32'(w.display_catch_up),
			32'(g.display_catch_up));
		check_field("ay_action", 32'(w.ay_action), 32'(g.ay_action));
		check_field("io_read_source", 32'(w.io_read_source), 32'(g.io_read_source));
		check_field("io_read_data", 32'(w.io_read_data), 32'(g.io_read_data));
		check_field("border_color", 32'(w.border_color), 32'(g.border_color));
		check_field("beeper_bits", 32'(w.beeper_bits), 32'(g.beeper_bits));
		check_field("screen_bank", 32'(w.screen_bank), 32'(g.screen_bank));
	endtask

	// Monitor: everything is sampled at the rising edge. An accepted access
	// is predicted first, then any result word is matched to the oldest
	// prediction, so even a result presented together with its access would line up.
	always @(posedge clk) begin
		word_taken = 1'b0;
		if (arst_n) begin
			if (cfg.valid && cfg.ready)
				fast_mode = cfg.data;
			if (req.valid && req.ready) begin
				predicted_results.push_back(predict_access(req.data));
				word_taken = 1'b1;
				accesses_taken++;
			end
			if (rsp.valid && rsp.ready) begin
				if (predicted_results.size() == 0) begin
					$display("%0t: result word with nothing expected, got 0x%0h",
						$time, rsp.data);
					mismatches++;
				end else begin
					want_word = predicted_results.pop_front();
					check_result(want_word, rsp.data);
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// Driver and receiver, both on the falling edge
	// ---------------------------------------------------------------

	// Sender: bursts of random length separated by random gaps; a word that
	// was not taken is held steady until the DUT takes it.
	always @(negedge clk) begin
		if (arst_n && (!req.valid || word_taken)) begin
			if (gap_left != 0 || pending_accesses.size() == 0) begin
				req.valid <= 1'b0;
				if (gap_left != 0)
					gap_left <= gap_left - 1;
			end else begin
				req.valid <= 1'b1;
				req.data <= pending_accesses.pop_front();
				if (burst_left <= 1) begin
					// a quarter of the bursts run straight into the next one
					burst_left <= $urandom_range(1, 24);
					gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				end else begin
					burst_left <= burst_left - 1;
				end
			end
		end
	end

	// Receiver: ready follows a randomly picked style, picked anew when its countdown runs out
	always @(negedge clk) begin
		if (rdy_left == 0) begin
			rdy_mode <= rdy_mode_t'($urandom_range(0, 3));
			rdy_left <= $urandom_range(16, 128);
			rdy_pattern <= 8'($urandom) | 8'h01;
			rsp.ready <= 1'b1;
		end else begin
			rdy_left <= rdy_left - 1;
			rdy_pattern <= {rdy_pattern[0], rdy_pattern[7:1]};
			case (rdy_mode)
				RDY_ALWAYS: rsp.ready <= 1'b1;
				RDY_COIN: rsp.ready <= 1'($urandom_range(0, 1));
				RDY_PATTERN: rsp.ready <= rdy_pattern[0];
				default: rsp.ready <= ($urandom_range(0, 7) != 0);
			endcase
		end
	end

	// ---------------------------------------------------------------
	// Stimulus
	// ---------------------------------------------------------------

	function automatic req_t make_access(logic [1:0] kind, logic [15:0] addr,
			logic [7:0] wdata, logic [7:0] fbus);
		req_t a;
		a.req_type = kind;
		a.address = addr;
		a.write_data = wdata;
		a.floating_bus = fbus;
		return a;
	endfunction

	// Random access. Io addresses are steered onto the decoded ports most of
	// the time. Until locking is allowed, any byte that could land in the
	// paging register has its lock bit cleared, since the lock only clears
	// at reset.
	function automatic req_t random_access(bit lock_ok);
		req_t        a;
		logic [15:0] r;
		a.req_type = 2'($urandom_range(0, 3));
		a.write_data = 8'($urandom);
		a.floating_bus = 8'($urandom);
		r = 16'($urandom);
		case ($urandom_range(0, 5))
			0: a.address = r;
			1: a.address = r & ~PAGING_MASK;
			2: a.address = (r & ~AY_MASK) | AY_SEL_PORT;
			3: a.address = (r & ~AY_MASK) | AY_DATA_PORT;
			4: a.address = {r[15:8], JOY_PORT};
			default: a.address = {r[15:1], 1'b0};
		endcase
		if (!lock_ok && a.req_type[1] && (a.address & PAGING_MASK) == '0) begin
			a.write_data[PG_LOCK] = 1'b0;
			a.floating_bus[PG_LOCK] = 1'b0;
		end
		return a;
	endfunction

	task automatic queue_access(req_t a);
		pending_accesses.push_back(a);
		accesses_queued++;
	endtask

	task automatic queue_random(int n, bit lock_ok);
		repeat (n) queue_access(random_access(lock_ok));
	endtask

	// stimulus holds off until every queued word is taken and every result is back
	task automatic wait_idle();
		while (accesses_taken != accesses_queued || predicted_results.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// one write on the config channel; only called while idle
	task automatic write_fast_mode(logic v);
		@(negedge clk);
		cfg.valid <= 1'b1;
		cfg.data <= v;
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
		@(negedge clk);
		cfg.valid <= 1'b0;
	endtask

	initial begin
		// every DUT input known from time zero
		arst_n = 1'b0;
		req.valid = 1'b0;
		req.data = '0;
		rsp.ready = 1'b0;
		cfg.valid = 1'b0;
		cfg.data = 1'b0;

		pg_reg = '0;
		pg_locked = 1'b0;
		border_q = '0;
		beeper_q = '0;
		fast_mode = 1'b0;
		word_taken = 1'b0;
		accesses_queued = 0;
		accesses_taken = 0;
		mismatches = 0;
		burst_left = 1;
		gap_left = 0;
		rdy_left = 0;
		rdy_mode = RDY_ALWAYS;
		rdy_pattern = 8'hFF;

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		// phase 0: normal timing, unlocked paging
		write_fast_mode(1'b0);

		// directed: slot map, ROM protect, every port decode, paging updates
		queue_access(make_access(REQ_MEM_RD, 16'h0000, 8'h00, 8'h00));
		queue_access(make_access(REQ_MEM_RD, 16'hFFFF, 8'h00, 8'hFF));
		queue_access(make_access(REQ_MEM_WR, 16'h3FFF, 8'hFF, 8'h00));  // ROM slot
		queue_access(make_access(REQ_MEM_WR, 16'h4000, 8'h00, 8'h00));  // screen slot
		queue_access(make_access(REQ_MEM_RD, 16'h8000, 8'h00, 8'h00));
		// paging write: RAM 7, ROM 1, shadow screen
		queue_access(make_access(REQ_IO_WR, 16'h7FFD, 8'h1F, 8'h00));
		queue_access(make_access(REQ_MEM_RD, 16'h0000, 8'h00, 8'h00));
		queue_access(make_access(REQ_MEM_RD, 16'hC123, 8'h00, 8'h00));  // odd bank
		queue_access(make_access(REQ_MEM_WR, 16'hFFFF, 8'hAA, 8'h00));
		queue_access(make_access(REQ_IO_WR, 16'hFFFD, 8'h07, 8'h00));   // AY select
		queue_access(make_access(REQ_IO_WR, 16'hBFFD, 8'hFF, 8'h00));   // AY data
		queue_access(make_access(REQ_IO_RD, 16'hFFFD, 8'h00, 8'h5A));   // AY read
		queue_access(make_access(REQ_IO_RD, 16'h001F, 8'h00, 8'hFF));   // joystick
		queue_access(make_access(REQ_IO_RD, 16'hFF1F, 8'h00, 8'h00));   // joystick
		queue_access(make_access(REQ_IO_RD, 16'h00FE, 8'h00, 8'hFF));   // keyboard
		queue_access(make_access(REQ_IO_WR, 16'h00FE, 8'hFF, 8'h00));   // border 7
		queue_access(make_access(REQ_IO_WR, 16'hFFFE, 8'h00, 8'h00));   // border 0
		// paging port read pulls in the floating bus, screen flips back
		queue_access(make_access(REQ_IO_RD, 16'h7FFD, 8'h00, 8'h10));
		queue_access(make_access(REQ_IO_RD, 16'h00FF, 8'h00, 8'hC5));   // plain fbus
		// even port that also decodes as paging
		queue_access(make_access(REQ_IO_WR, 16'h0000, 8'h0F, 8'h00));
		queue_access(make_access(REQ_MEM_RD, 16'hC000, 8'h00, 8'h00));
		queue_access(make_access(REQ_IO_RD, 16'h0001, 8'h00, 8'hDF));
		queue_access(make_access(REQ_MEM_WR, 16'h8000, 8'h55, 8'h00));
		queue_random(400, 1'b0);
		wait_idle();

		// phase 1: fast load, strobes masked
		write_fast_mode(1'b1);
		queue_random(300, 1'b0);
		wait_idle();

		// phase 2: back to normal, with a full drain in the middle
		write_fast_mode(1'b0);
		queue_random(150, 1'b0);
		wait_idle();
		queue_random(150, 1'b0);
		wait_idle();

		// phase 3: lock paging, then show later loads are dropped
		write_fast_mode(1'b0);
		queue_access(make_access(REQ_IO_WR, 16'h7FFD, 8'h3A, 8'h00));  // sets lock
		queue_access(make_access(REQ_IO_WR, 16'h7FFD, 8'h1F, 8'h00));  // ignored
		queue_access(make_access(REQ_IO_RD, 16'h7FFD, 8'h00, 8'h08));  // ignored
		queue_access(make_access(REQ_MEM_RD, 16'hC000, 8'h00, 8'h00));
		queue_access(make_access(REQ_MEM_RD, 16'h0000, 8'h00, 8'h00));
		queue_random(250, 1'b1);
		wait_idle();

		// phase 4: fast load while locked
		write_fast_mode(1'b1);
		queue_random(200, 1'b1);
		wait_idle();

		repeat (10) @(negedge clk);
		if (mismatches == 0)
			$display("banked_memory_and_port_decoder_unit regression: pass");
		else
			$display("banked_memory_and_port_decoder_unit regression: fail");
		$finish;
	end

endmodule

### banked_memory_and_port_decoder_unit.f
rtl/core/bmpd_pkg.sv
rtl/core/bmpd_req_if.sv
rtl/core/bmpd_rsp_if.sv
rtl/core/bmpd_cfg_if.sv
rtl/core/bmpd_decode.sv
rtl/core/banked_memory_and_port_decoder_unit.sv
sim/tb_banked_memory_and_port_decoder_unit.sv
